// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/mpqa_pkg.sv =====
// Types, constants and command/status structs of the priority queue.
package mpqa_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic shift_start;
        logic shift;
        logic rem_finish;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic          full;
        logic          empty;
        logic          scan_done;
        logic          shift_done;
        logic [CW-1:0] count;
    } t_sts;

endpackage

// ===== rtl/mpqa_in_if.sv =====
// Request channel of the priority queue: operation and value.
interface mpqa_in_if;
    logic                       valid;
    logic                       ready;
    mpqa_pkg::t_op              op;
    logic signed [mpqa_pkg::DW-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== rtl/mpqa_out_if.sv =====
// Result channel of the priority queue: status, removed value, count.
interface mpqa_out_if;
    logic                           valid;
    logic                           ready;
    mpqa_pkg::t_status              status;
    logic signed [mpqa_pkg::DW-1:0] removed_value;
    logic [mpqa_pkg::CW-1:0]        count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    output ready);
endinterface

// ===== rtl/max_priority_queue_array_unit.sv =====
// Top level of the unsorted-array max priority queue.
// Requests arrive on i_in (op, value); each request gives exactly one result on
// o_out (status, removed_value, count), in request order.
// An insert appends the value at the tail, or returns status full. A remove
// returns the largest signed value held (the earliest one on a tie) and closes
// the gap, keeping arrival order; on an empty queue it returns status empty.
// An insert or a rejected request goes from idle straight to the finish state. A
// remove on a non-empty queue scans the held entries for the largest, then shifts
// the entries after it down one place, then loads and presents the result.
// Scan and shift use the single read port of the entry memory once a cycle.
// One request is in work at a time; i_in.ready is high while the block is idle.
// The next request is taken while the previous result still waits in the output
// register; a stalled receiver holds the result and the finished request waits
// until the register frees.
// Reset (synchronous, active low) empties the queue at once; no clearing pass.
`include "assert_macros.svh"

module max_priority_queue_array_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpqa_in_if.sink    i_in,
    mpqa_out_if.source o_out
);

    mpqa_pkg::t_cmd cmd;
    mpqa_pkg::t_sts sts;

    mpqa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mpqa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_in.op),
        .i_value         (i_in.value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_out.status),
        .o_removed_value (o_out.removed_value),
        .o_count         (o_out.count)
    );

    // Never overwrite a result that the receiver has not taken
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, !o_out.valid || o_out.ready, "result overwritten")

    // An accepted insert into a non-full queue grows the count by one
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, cmd.accept && (i_in.op == mpqa_pkg::OP_INSERT) && !sts.full, sts.count == $past(sts.count) + mpqa_pkg::CW'(1), "insert count")

    // The count never passes the capacity
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, sts.count <= mpqa_pkg::CW'(mpqa_pkg::DEPTH), "count over capacity")

endmodule

// ===== rtl/mpqa_dp.sv =====
// Datapath of the priority queue: entry memory, scan and shift logic, result registers.
module mpqa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mpqa_pkg::t_op                  i_op,
    input  logic signed [mpqa_pkg::DW-1:0] i_value,
    input  mpqa_pkg::t_cmd                 i_cmd,
    output mpqa_pkg::t_sts                 o_sts,
    output mpqa_pkg::t_status              o_status,
    output logic signed [mpqa_pkg::DW-1:0] o_removed_value,
    output logic [mpqa_pkg::CW-1:0]        o_count
);

    localparam int AW = mpqa_pkg::AW;
    localparam int CW = mpqa_pkg::CW;
    localparam int DW = mpqa_pkg::DW;

    logic signed [DW-1:0] r_mem [mpqa_pkg::DEPTH];
    logic signed [DW-1:0] r_rd_data;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_issue;
    logic                 r_pend;
    logic [AW-1:0]        r_pend_idx;
    logic signed [DW-1:0] r_best_val;
    logic [AW-1:0]        r_best_idx;
    mpqa_pkg::t_status    r_res_status;
    logic signed [DW-1:0] r_res_val;

    logic                 full;
    logic                 empty;
    logic                 issue_live;
    logic                 step;
    logic                 ins_ok;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;

    assign full       = (r_cnt == CW'(mpqa_pkg::DEPTH));
    assign empty      = (r_cnt == '0);
    assign issue_live = (r_issue < r_cnt);
    assign step       = i_cmd.scan || i_cmd.shift;
    assign ins_ok     = i_cmd.accept && (i_op == mpqa_pkg::OP_INSERT) && !full;

    // Memory port control: one read for scan and shift, one write for insert and shift
    assign rd_en   = step && issue_live;
    assign rd_addr = r_issue[AW-1:0];
    assign wr_en   = ins_ok || (i_cmd.shift && r_pend);
    assign wr_addr = i_cmd.accept ? r_cnt[AW-1:0] : (r_pend_idx - AW'(1));
    assign wr_data = i_cmd.accept ? i_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Count, read pointer and pending-read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_issue <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_issue <= '0;
                r_pend  <= 1'b0;
                if (ins_ok) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (step) begin
                r_pend <= issue_live;
                if (issue_live) begin
                    r_issue <= r_issue + CW'(1);
                end
            end
            // Restart the pointer just past the removed entry
            if (i_cmd.shift_start) begin
                r_issue <= CW'(r_best_idx) + CW'(1);
                r_pend  <= 1'b0;
            end
            if (i_cmd.rem_finish) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Track the running maximum; a later equal value does not replace it
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_idx <= r_issue[AW-1:0];
        end
        if (i_cmd.scan && r_pend) begin
            if ((r_pend_idx == '0) || (r_rd_data > r_best_val)) begin
                r_best_val <= r_rd_data;
                r_best_idx <= r_pend_idx;
            end
        end
    end

    // Result of the current request, then the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_val <= '0;
            if (i_op == mpqa_pkg::OP_INSERT) begin
                r_res_status <= full ? mpqa_pkg::STS_FULL : mpqa_pkg::STS_DONE;
            end else begin
                r_res_status <= empty ? mpqa_pkg::STS_EMPTY : mpqa_pkg::STS_DONE;
            end
        end
        if (i_cmd.rem_finish) begin
            r_res_status <= mpqa_pkg::STS_DONE;
            r_res_val    <= r_best_val;
        end
        if (i_cmd.load_out) begin
            o_status        <= r_res_status;
            o_removed_value <= r_res_val;
            o_count         <= r_cnt;
        end
    end

    always_comb begin
        o_sts.full       = full;
        o_sts.empty      = empty;
        o_sts.scan_done  = !issue_live && !r_pend;
        o_sts.shift_done = !issue_live && !r_pend;
        o_sts.count      = r_cnt;
    end

endmodule

// ===== rtl/mpqa_ctrl.sv =====
// Controller of the priority queue: sequences accept, scan, shift and result hand-off.
module mpqa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mpqa_pkg::t_op  i_op,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  mpqa_pkg::t_sts i_sts,
    output mpqa_pkg::t_cmd o_cmd
);

    mpqa_pkg::t_state r_state;
    mpqa_pkg::t_state n_state;
    logic             r_out_valid;
    logic             can_load;

    assign can_load = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpqa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpqa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if ((i_op == mpqa_pkg::OP_REMOVE) && !i_sts.empty) begin
                        n_state = mpqa_pkg::ST_SCAN;
                    end else begin
                        n_state = mpqa_pkg::ST_FINISH;
                    end
                end
            end
            mpqa_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = mpqa_pkg::ST_SHIFT;
                end
            end
            mpqa_pkg::ST_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = mpqa_pkg::ST_FINISH;
                end
            end
            mpqa_pkg::ST_FINISH: begin
                if (can_load) begin
                    n_state = mpqa_pkg::ST_IDLE;
                end
            end
            default: n_state = mpqa_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mpqa_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            mpqa_pkg::ST_SCAN: begin
                o_cmd.scan        = !i_sts.scan_done;
                o_cmd.shift_start = i_sts.scan_done;
            end
            mpqa_pkg::ST_SHIFT: begin
                o_cmd.shift      = !i_sts.shift_done;
                o_cmd.rem_finish = i_sts.shift_done;
            end
            mpqa_pkg::ST_FINISH: begin
                o_cmd.load_out = can_load;
            end
            default: o_cmd = '0;
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sim/max_priority_queue_array_unit_test.sv =====
// Testbench of the array max priority queue: random insert/remove traffic checked against a predictor.
module max_priority_queue_array_unit_test;

    localparam int DEPTH = mpqa_pkg::DEPTH;
    localparam int DW    = mpqa_pkg::DW;
    localparam int CW    = mpqa_pkg::CW;

    localparam int RANDOM_ITEMS    = 1400;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int TAIL_CYCLES     = 4 * DEPTH + 10;

    localparam logic signed [DW-1:0] MAX_VALUE = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_VALUE = {1'b1, {(DW-1){1'b0}}};

    typedef struct {
        mpqa_pkg::t_op        op;
        logic signed [DW-1:0] value;
        bit                   wait_drain;
    } t_pq_request;

    typedef struct {
        mpqa_pkg::t_status    status;
        logic signed [DW-1:0] removed_value;
        logic [CW-1:0]        count;
    } t_pq_result;

    typedef enum {
        RX_ALWAYS,
        RX_TOGGLE,
        RX_COIN,
        RX_RARE_STALL,
        RX_MOSTLY_STALL
    } t_rx_pattern;

    logic i_clk;
    logic i_rst_n;

    mpqa_in_if  req_if();
    mpqa_out_if rsp_if();

    max_priority_queue_array_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    t_pq_request          pending_requests[$];
    t_pq_result           expected_results[$];
    logic signed [DW-1:0] held_values[DEPTH];
    int                   held_count;
    int                   gen_fill;
    int                   items_queued;
    int                   errors;
    int                   results_seen;
    int                   idle_cycles;
    int                   burst_left;
    int                   gap_left;
    t_rx_pattern          rx_pattern;
    int                   rx_phase_left;
    int                   hold_left;
    bit                   hold_done;

    // Clock: period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Apply one accepted request to the predicted queue and return its result
    function automatic t_pq_result apply_request(mpqa_pkg::t_op op,
                                                 logic signed [DW-1:0] value);
        t_pq_result r;
        int         top;
        r.status        = mpqa_pkg::STS_DONE;
        r.removed_value = '0;
        if (op == mpqa_pkg::OP_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = mpqa_pkg::STS_FULL;
            end else begin
                held_values[held_count] = value;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = mpqa_pkg::STS_EMPTY;
        end else begin
            // earliest maximum wins a tie
            top = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_values[i] > held_values[top]) begin
                    top = i;
                end
            end
            r.removed_value = held_values[top];
            for (int i = top; i < held_count - 1; i++) begin
                held_values[i] = held_values[i + 1];
            end
            held_count--;
        end
        r.count = CW'(held_count);
        return r;
    endfunction

    // Draw an insert value; narrow draws cluster on a few values to force ties
    function automatic logic signed [DW-1:0] draw_value(bit narrow);
        int roll;
        roll = $urandom_range(0, 9);
        if (narrow) begin
            if (roll < 3) begin
                return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
            end
            return DW'(int'($urandom_range(0, 4)) - 2);
        end
        if (roll < 6) begin
            return $urandom;
        end
        if (roll < 8) begin
            return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
        end
        return DW'(int'($urandom_range(0, 16)) - 8);
    endfunction

    // Queue one request and track the fill level it leads to
    task automatic push_request(mpqa_pkg::t_op op, logic signed [DW-1:0] value,
                                bit wait_drain);
        t_pq_request req;
        req.op         = op;
        req.value      = value;
        req.wait_drain = wait_drain;
        pending_requests.push_back(req);
        items_queued++;
        if (op == mpqa_pkg::OP_INSERT && gen_fill < DEPTH) begin
            gen_fill++;
        end else if (op == mpqa_pkg::OP_REMOVE && gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    // Sender: bursts with random gaps, optional wait for all results
    always @(posedge i_clk) begin
        bit offer;
        bit taken;
        offer = 1'b0;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            taken = req_if.valid && req_if.ready;
            if (taken) begin
                expected_results.push_back(apply_request(req_if.op, req_if.value));
                void'(pending_requests.pop_front());
            end
            if (req_if.valid && !taken) begin
                // hold the request until it is taken
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                if (!(pending_requests[0].wait_drain && expected_results.size() != 0)) begin
                    offer = 1'b1;
                    req_if.op    <= pending_requests[0].op;
                    req_if.value <= pending_requests[0].value;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
                    end else begin
                        burst_left--;
                    end
                end
            end
            req_if.valid <= offer;
        end
    end

    // Receiver: check each result, then pick ready from the current pattern
    always @(posedge i_clk) begin
        t_pq_result want;
        bit         rdy;
        rdy = 1'b1;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request pending: status %0d removed %0d count %0d",
                             $time, rsp_if.status, rsp_if.removed_value, rsp_if.count);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, rsp_if.status);
                    end
                    if (rsp_if.removed_value !== want.removed_value) begin
                        errors++;
                        $display("%0t: removed_value mismatch: expected %0d, got %0d",
                                 $time, want.removed_value, rsp_if.removed_value);
                    end
                    if (rsp_if.count !== want.count) begin
                        errors++;
                        $display("%0t: count mismatch: expected %0d, got %0d",
                                 $time, want.count, rsp_if.count);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_OFF_AFTER
                         && pending_requests.size() > 2
                         && !pending_requests[0].wait_drain
                         && !pending_requests[1].wait_drain
                         && !pending_requests[2].wait_drain) begin
                // long hold-off: let the block fill up and stall its input
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                rdy       = 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_pattern    = t_rx_pattern'($urandom_range(0, 4));
                    rx_phase_left = $urandom_range(20, 120);
                end
                rx_phase_left--;
                case (rx_pattern)
                    RX_ALWAYS:       rdy = 1'b1;
                    RX_TOGGLE:       rdy = !rsp_if.ready;
                    RX_COIN:         rdy = ($urandom_range(0, 1) == 1);
                    RX_RARE_STALL:   rdy = ($urandom_range(0, 9) != 0);
                    RX_MOSTLY_STALL: rdy = ($urandom_range(0, 7) == 0);
                    default:         rdy = 1'b1;
                endcase
            end
            rsp_if.ready <= rdy;
        end
    end

    // Count cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int  roll;
        int  n;
        bit  mark;
        bit  first_seq;
        req_if.valid = 1'b0;
        req_if.op    = mpqa_pkg::OP_INSERT;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        first_seq    = 1'b1;

        // Directed: remove when empty, extremes, ties, fill to full, insert when full
        push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, MAX_VALUE, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, MIN_VALUE, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, '0, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, -1, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, 1, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, MAX_VALUE, 1'b0);
        push_request(mpqa_pkg::OP_INSERT, MIN_VALUE, 1'b0);
        push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
        push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
        push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
        while (gen_fill < DEPTH) begin
            push_request(mpqa_pkg::OP_INSERT, draw_value(1'b0), 1'b0);
        end
        push_request(mpqa_pkg::OP_INSERT, MAX_VALUE, 1'b0);

        // Random: mostly fill/drain sequences with random content, some noise
        n = items_queued + RANDOM_ITEMS;
        while (items_queued < n) begin
            roll      = $urandom_range(0, 9);
            mark      = first_seq || ($urandom_range(0, 9) == 0);
            first_seq = 1'b0;
            if (roll < 4) begin
                // fill by a random amount, then drain past empty now and then
                repeat ($urandom_range(1, DEPTH)) begin
                    push_request(mpqa_pkg::OP_INSERT, draw_value(1'b0), mark);
                    mark = 1'b0;
                end
                repeat (gen_fill + $urandom_range(0, 1)) begin
                    push_request(mpqa_pkg::OP_REMOVE, $urandom, mark);
                end
            end else if (roll < 6) begin
                // overfill, then take some out
                while (gen_fill < DEPTH) begin
                    push_request(mpqa_pkg::OP_INSERT, draw_value(1'b0), mark);
                    mark = 1'b0;
                end
                repeat ($urandom_range(1, 3)) begin
                    push_request(mpqa_pkg::OP_INSERT, draw_value(1'b0), mark);
                    mark = 1'b0;
                end
                repeat ($urandom_range(1, DEPTH)) begin
                    push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
                end
            end else if (roll < 8) begin
                // mixed operations
                repeat ($urandom_range(4, 24)) begin
                    if ($urandom_range(0, 1)) begin
                        push_request(mpqa_pkg::OP_REMOVE, $urandom, mark);
                    end else begin
                        push_request(mpqa_pkg::OP_INSERT, draw_value(1'b0), mark);
                    end
                    mark = 1'b0;
                end
            end else if (roll < 9) begin
                // many equal values to exercise tie handling
                repeat ($urandom_range(2, DEPTH)) begin
                    push_request(mpqa_pkg::OP_INSERT, draw_value(1'b1), mark);
                    mark = 1'b0;
                end
                repeat ($urandom_range(1, DEPTH)) begin
                    push_request(mpqa_pkg::OP_REMOVE, $urandom, 1'b0);
                end
            end else begin
                // drain everything and knock on the empty queue
                repeat (gen_fill + $urandom_range(1, 3)) begin
                    push_request(mpqa_pkg::OP_REMOVE, $urandom, mark);
                    mark = 1'b0;
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until everything is sent and answered
        while ((pending_requests.size() != 0 || expected_results.size() != 0)
               && idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d requests pending, %0d results outstanding",
                     $time, pending_requests.size(), expected_results.size());
            $display("Regression FAIL");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (errors == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
        end
        $finish;
    end

endmodule
